### src/rcfd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Remote-control frame decoder package
// Shared types and constants for the 18-byte receiver frame decoder.
// ----------------------------------------------------------------------------
package rcfd_pkg;

    // Frame layout.
    localparam int unsigned FRAME_BYTES = 18;
    localparam int unsigned POS_W       = 5;

    // Stick channel width and register reset values.
    localparam int unsigned CH_W = 11;
    localparam logic [CH_W-1:0] CH_MIN_RST    = 11'd364;
    localparam logic [CH_W-1:0] CH_MAX_RST    = 11'd1684;
    localparam logic [CH_W-1:0] CH_CENTER_RST = 11'd1024;

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_CH_MIN    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CH_MAX    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CH_CENTER = 2'd2;

    // Scaling: q = round(mag * 16384 / 660) = floor((mag * 4096 + 82) / 165).
    // The divide by 165 is a multiply by ceil(2^31 / 165) and a shift by 31,
    // exact for every numerator below 2^31 / 97.
    localparam int unsigned NUM_SCALED  = 5;
    localparam int unsigned NUMER_W     = 23;
    localparam int unsigned RECIP_W     = 24;
    localparam int unsigned PROD_W      = NUMER_W + RECIP_W;
    localparam int unsigned RECIP_SHIFT = 31;
    localparam logic [RECIP_W-1:0] RECIP      = 24'd13015053;
    localparam logic [NUMER_W-1:0] ROUND_BIAS = 23'd82;
    localparam logic [CH_W-1:0]    MAG_SAT    = 11'h7FF;

    // Q2.14 saturation limits.
    localparam logic [15:0] Q_POS_MAX = 16'h7FFF;
    localparam logic [15:0] Q_NEG_MAG = 16'h8000;

    // One assembled frame, byte 0 in the lowest lane.
    typedef logic [FRAME_BYTES-1:0][7:0] t_frame;

    // Configuration registers as seen by the decode pipeline.
    typedef struct packed {
        logic [CH_W-1:0] ch_min;
        logic [CH_W-1:0] ch_max;
        logic [CH_W-1:0] center;
    } t_cfg;

    // One decoded result item.
    typedef struct packed {
        logic signed [15:0] stick_right_h;
        logic signed [15:0] stick_right_v;
        logic signed [15:0] stick_left_h;
        logic signed [15:0] stick_left_v;
        logic signed [15:0] dial_level;
        logic [3:0]         switch_pair;
        logic signed [15:0] pointer_x;
        logic signed [15:0] pointer_y;
        logic signed [15:0] pointer_z;
        logic [9:0]         key_and_button_bits;
        logic               frame_ok;
        logic               resync_request;
    } t_result;

endpackage
`default_nettype wire

### src/rcfd_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Frame assembler
// Tracks the byte position, stores incoming bytes and hands a complete
// frame to the frame queue when the last byte arrives.
// ----------------------------------------------------------------------------
module rcfd_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_accept,
    input  wire logic [7:0]    i_byte_value,
    input  wire logic          i_frame_start,
    output logic               o_push,
    output rcfd_pkg::t_frame   o_frame
);
    import rcfd_pkg::*;

    logic [POS_W-1:0] r_pos;
    logic [POS_W-1:0] n_pos;
    logic [POS_W-1:0] w_pos_cur;
    logic             w_last;
    logic [7:0]       r_store [FRAME_BYTES];

    // A frame start, or a stray position, puts the byte at position zero.
    always_comb begin
        w_pos_cur = (i_frame_start || (r_pos >= POS_W'(FRAME_BYTES))) ? '0 : r_pos;
        w_last    = (w_pos_cur == POS_W'(FRAME_BYTES - 1));
        n_pos     = w_last ? '0 : w_pos_cur + 1'b1;
    end

    // Position counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (i_accept) begin
            r_pos <= n_pos;
        end
    end

    // Byte store; entries are always written before a frame reads them.
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_store[w_pos_cur] <= i_byte_value;
        end
    end

    // The last byte goes straight into the frame alongside the stored ones.
    always_comb begin
        for (int b = 0; b < FRAME_BYTES - 1; b++) begin
            o_frame[b] = r_store[b];
        end
        o_frame[FRAME_BYTES-1] = i_byte_value;
        o_push = i_accept && w_last;
    end

endmodule
`default_nettype wire

### src/rcfd_frame_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Frame queue
// Short queue of complete frames between the assembler and the decoder.
// ----------------------------------------------------------------------------
module rcfd_frame_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  rcfd_pkg::t_frame   i_frame,
    output logic               o_full,
    input  wire logic          i_pop,
    output logic               o_empty,
    output rcfd_pkg::t_frame   o_frame
);
    import rcfd_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_frame         r_mem [DEPTH];
    logic [AW-1:0]  r_wr;
    logic [AW-1:0]  r_rd;
    logic [CW-1:0]  r_cnt;
    logic           w_push;
    logic           w_pop;

    always_comb begin
        o_full  = (r_cnt == CW'(DEPTH));
        o_empty = (r_cnt == '0);
        w_push  = i_push && !o_full;
        w_pop   = i_pop && !o_empty;
        o_frame = r_mem[r_rd];
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Frame storage.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_frame;
        end
    end

endmodule
`default_nettype wire

### src/rcfd_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Frame decoder
// Three-stage decode pipeline (unpack and check, scale multiply, saturate)
// feeding a small result queue. A frame is taken only when the result queue
// has room for it and for every frame still in the pipeline.
// ----------------------------------------------------------------------------
module rcfd_back #(
    parameter int DEPTH = 4
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  rcfd_pkg::t_cfg     i_cfg,
    input  wire logic          i_frame_valid,
    input  rcfd_pkg::t_frame   i_frame,
    output logic               o_frame_pop,
    input  wire logic          i_pop,
    output logic               o_empty,
    output rcfd_pkg::t_result  o_result
);
    import rcfd_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    // Split a raw value into sign and clamped magnitude of (raw - center).
    function automatic logic [CH_W:0] f_mag(input logic [15:0] raw,
                                            input logic [CH_W-1:0] center);
        logic [16:0] diff;
        logic [16:0] mag;
        diff = {1'b0, raw} - {6'b0, center};
        mag  = diff[16] ? (~diff + 17'd1) : diff;
        f_mag = {diff[16], (mag > 17'(MAG_SAT)) ? MAG_SAT : mag[CH_W-1:0]};
    endfunction

    // Apply sign and Q2.14 saturation to a rounded quotient.
    function automatic logic [15:0] f_sat(input logic neg, input logic [15:0] q);
        if (neg) begin
            f_sat = (q > Q_NEG_MAG) ? Q_NEG_MAG : (~q + 16'd1);
        end else begin
            f_sat = (q > Q_POS_MAX) ? Q_POS_MAX : q;
        end
    endfunction

    logic [CH_W-1:0]   w_ch [4];
    logic [15:0]       w_raw [NUM_SCALED];
    logic              w_ok;
    t_result           n_a_res;
    logic [CH_W:0]     w_mag [NUM_SCALED];
    logic              w_take;

    logic              r_a_valid;
    t_result           r_a_res;
    logic [CH_W-1:0]   r_a_mag [NUM_SCALED];
    logic              r_a_neg [NUM_SCALED];

    logic              r_b_valid;
    t_result           r_b_res;
    logic [PROD_W-1:0] r_b_prod [NUM_SCALED];
    logic              r_b_neg [NUM_SCALED];

    logic [15:0]       w_scaled [NUM_SCALED];
    t_result           w_c_res;

    t_result           r_mem [DEPTH];
    logic [AW-1:0]     r_wr;
    logic [AW-1:0]     r_rd;
    logic [CW-1:0]     r_cnt;
    logic              w_pop;
    logic [CW:0]       w_reserved;

    // Take a frame when the result queue can hold it after everything in flight.
    always_comb begin
        w_reserved  = {1'b0, r_cnt} + (CW+1)'(r_a_valid) + (CW+1)'(r_b_valid);
        w_take      = i_frame_valid && (w_reserved < (CW+1)'(DEPTH));
        o_frame_pop = w_take;
    end

    // Unpack the channels and check them against the window.
    always_comb begin
        w_ch[0] = {i_frame[1][2:0], i_frame[0]};
        w_ch[1] = {i_frame[2][5:0], i_frame[1][7:3]};
        w_ch[2] = {i_frame[4][0], i_frame[3], i_frame[2][7:6]};
        w_ch[3] = {i_frame[5][3:0], i_frame[4][7:1]};
        w_ok = 1'b1;
        for (int c = 0; c < 4; c++) begin
            if ((w_ch[c] < i_cfg.ch_min) || (w_ch[c] > i_cfg.ch_max)) begin
                w_ok = 1'b0;
            end
            w_raw[c] = {5'b0, w_ch[c]};
        end
        w_raw[4] = {i_frame[17], i_frame[16]};
        for (int l = 0; l < NUM_SCALED; l++) begin
            w_mag[l] = f_mag(w_raw[l], i_cfg.center);
        end
        n_a_res = '0;
        if (w_ok) begin
            n_a_res.switch_pair         = i_frame[5][7:4];
            n_a_res.pointer_x           = {i_frame[7], i_frame[6]};
            n_a_res.pointer_y           = {i_frame[9], i_frame[8]};
            n_a_res.pointer_z           = {i_frame[11], i_frame[10]};
            n_a_res.key_and_button_bits = {i_frame[13][0], i_frame[12][0], i_frame[14]};
            n_a_res.frame_ok            = 1'b1;
        end else begin
            n_a_res.resync_request = 1'b1;
        end
    end

    // Pipeline valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            r_a_valid <= w_take;
            r_b_valid <= r_a_valid;
        end
    end

    // Stage A registers, then the reciprocal multiply in stage B.
    always_ff @(posedge i_clk) begin
        r_a_res <= n_a_res;
        r_b_res <= r_a_res;
        for (int l = 0; l < NUM_SCALED; l++) begin
            r_a_neg[l]  <= w_mag[l][CH_W];
            r_a_mag[l]  <= w_mag[l][CH_W-1:0];
            r_b_neg[l]  <= r_a_neg[l];
            r_b_prod[l] <= PROD_W'({r_a_mag[l], 12'b0} + ROUND_BIAS) * PROD_W'(RECIP);
        end
    end

    // Stage C: quotient, sign and saturation; a bad frame keeps zeros.
    always_comb begin
        for (int l = 0; l < NUM_SCALED; l++) begin
            w_scaled[l] = f_sat(r_b_neg[l], r_b_prod[l][RECIP_SHIFT +: 16]);
        end
        w_c_res = r_b_res;
        if (r_b_res.frame_ok) begin
            w_c_res.stick_right_h = w_scaled[0];
            w_c_res.stick_right_v = w_scaled[1];
            w_c_res.stick_left_h  = w_scaled[2];
            w_c_res.stick_left_v  = w_scaled[3];
            w_c_res.dial_level    = w_scaled[4];
        end
    end

    // Result queue control.
    always_comb begin
        o_empty  = (r_cnt == '0);
        w_pop    = i_pop && !o_empty;
        o_result = r_mem[r_rd];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (r_b_valid) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (r_b_valid && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !r_b_valid) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Result storage.
    always_ff @(posedge i_clk) begin
        if (r_b_valid) begin
            r_mem[r_wr] <= w_c_res;
        end
    end

endmodule
`default_nettype wire

### src/remote_control_frame_decoder_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Remote-control frame decoder
// Decodes 18-byte receiver frames into scaled stick channels, dial, switches,
// mouse axes and key bits, with a window check on the stick channels.
// ----------------------------------------------------------------------------
// Usage:
//   Bytes enter through a queue-style port: an item is taken when push is
//   high and full is low. frame_start marks byte 0 of a frame; otherwise the
//   position advances and wraps after byte 17.
//   Each completed frame yields one result, held on the o_ ports while empty
//   is low and removed when pop is high. Bytes that do not finish a frame
//   yield nothing.
//   Path: a result passes through the frame queue, check stage, multiply
//   stage and result queue write before it becomes visible.
//   Throughput: one byte per cycle while full is low; the decode pipeline takes
//   one frame per cycle, limited only by free space in the result queue.
//   If the receiver stops popping, results pile up in the result queue, then
//   frames in the frame queue, and only then does full rise.
//   Reset clears the position, both queues and the pipeline, and loads the
//   window and center registers with their defaults (364, 1684, 1024).
//   Configuration writes take effect at once and are meant for idle periods.
// ----------------------------------------------------------------------------
module remote_control_frame_decoder_core #(
    parameter int FRAME_QUEUE_DEPTH = 2,
    parameter int RESULT_DEPTH      = 4
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         push,
    output logic                              full,
    input  wire logic [7:0]                   i_byte_value,
    input  wire logic                         i_frame_start,
    output logic                              empty,
    input  wire logic                         pop,
    output logic signed [15:0]                o_stick_right_h,
    output logic signed [15:0]                o_stick_right_v,
    output logic signed [15:0]                o_stick_left_h,
    output logic signed [15:0]                o_stick_left_v,
    output logic signed [15:0]                o_dial_level,
    output logic [3:0]                        o_switch_pair,
    output logic signed [15:0]                o_pointer_x,
    output logic signed [15:0]                o_pointer_y,
    output logic signed [15:0]                o_pointer_z,
    output logic [9:0]                        o_key_and_button_bits,
    output logic                              o_frame_ok,
    output logic                              o_resync_request,
    input  wire logic                         i_cfg_wr_en,
    input  wire logic [rcfd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [rcfd_pkg::CH_W-1:0]    i_cfg_data
);
    import rcfd_pkg::*;

    t_cfg    r_cfg;
    logic    w_accept;
    logic    w_front_push;
    t_frame  w_front_frame;
    logic    w_q_full;
    logic    w_q_empty;
    logic    w_q_pop;
    t_frame  w_q_frame;
    t_result w_result;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ch_min <= CH_MIN_RST;
            r_cfg.ch_max <= CH_MAX_RST;
            r_cfg.center <= CH_CENTER_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_CH_MIN:    r_cfg.ch_min <= i_cfg_data;
                CFG_CH_MAX:    r_cfg.ch_max <= i_cfg_data;
                CFG_CH_CENTER: r_cfg.center <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Input handshake.
    assign full     = w_q_full;
    assign w_accept = push && !w_q_full;

    rcfd_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (w_accept),
        .i_byte_value  (i_byte_value),
        .i_frame_start (i_frame_start),
        .o_push        (w_front_push),
        .o_frame       (w_front_frame)
    );

    rcfd_frame_queue #(
        .DEPTH (FRAME_QUEUE_DEPTH)
    ) u_frame_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_front_push),
        .i_frame (w_front_frame),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_empty (w_q_empty),
        .o_frame (w_q_frame)
    );

    rcfd_back #(
        .DEPTH (RESULT_DEPTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_frame_valid (!w_q_empty),
        .i_frame       (w_q_frame),
        .o_frame_pop   (w_q_pop),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_result      (w_result)
    );

    // Result fields.
    assign o_stick_right_h       = w_result.stick_right_h;
    assign o_stick_right_v       = w_result.stick_right_v;
    assign o_stick_left_h        = w_result.stick_left_h;
    assign o_stick_left_v        = w_result.stick_left_v;
    assign o_dial_level          = w_result.dial_level;
    assign o_switch_pair         = w_result.switch_pair;
    assign o_pointer_x           = w_result.pointer_x;
    assign o_pointer_y           = w_result.pointer_y;
    assign o_pointer_z           = w_result.pointer_z;
    assign o_key_and_button_bits = w_result.key_and_button_bits;
    assign o_frame_ok            = w_result.frame_ok;
    assign o_resync_request      = w_result.resync_request;

    // A shown result is either good or a resync request, never both.
    a_ok_xor_resync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_frame_ok != o_resync_request))
        else $error("result is neither clearly good nor clearly bad");

    // A bad frame carries only zeros.
    a_bad_frame_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_frame_ok) |->
            (o_stick_right_h == 16'sd0) && (o_stick_right_v == 16'sd0) &&
            (o_stick_left_h == 16'sd0) && (o_stick_left_v == 16'sd0) &&
            (o_dial_level == 16'sd0) && (o_switch_pair == 4'd0) &&
            (o_pointer_x == 16'sd0) && (o_pointer_y == 16'sd0) &&
            (o_pointer_z == 16'sd0) && (o_key_and_button_bits == 10'd0))
        else $error("bad frame result has nonzero fields");

    // The assembler never hands a frame to a full frame queue.
    a_no_queue_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_front_push |-> !w_q_full)
        else $error("frame pushed into full frame queue");

    // After reset no result is shown.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("result visible right after reset");

endmodule
`default_nettype wire
